// ===== sv/dsfo_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth sort face order package
// Shared sizes, opcodes and control structures of the depth sorter.
// ----------------------------------------------------------------------------
package dsfo_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;
  localparam int DEPTH_W  = 32;
  localparam int TAG_W    = 16;
  localparam int ENTRY_W  = DEPTH_W + TAG_W;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DRAW  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic draw_start;
    logic scan_start;
    logic take;
    logic commit;
  } sel_ctl_t;

endpackage

// ===== sv/dsfo_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dsfo_sel.sv =====
// ----------------------------------------------------------------------------
// Depth sort selection unit
// Finds, over one scan of the store, the entry that follows the previously
// emitted entry in descending depth order with ties broken by slot.
// ----------------------------------------------------------------------------
module dsfo_sel import dsfo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sel_ctl_t                  ctl,
  input  logic signed [DEPTH_W-1:0] in_depth,
  input  logic [TAG_W-1:0]          in_tag,
  input  logic [SLOT_W-1:0]         in_slot,
  output logic signed [DEPTH_W-1:0] best_depth,
  output logic [TAG_W-1:0]          best_tag,
  output logic [SLOT_W-1:0]         best_slot
);

  logic                      first_r;
  logic                      found_r;
  logic signed [DEPTH_W-1:0] prev_depth_r;
  logic [SLOT_W-1:0]         prev_slot_r;
  logic signed [DEPTH_W-1:0] best_depth_r;
  logic [TAG_W-1:0]          best_tag_r;
  logic [SLOT_W-1:0]         best_slot_r;
  logic                      eligible;
  logic                      better;
  logic                      update;

  // Slots arrive in ascending order, so a strictly deeper entry wins and an
  // equal one keeps the earlier slot.
  assign eligible = first_r || (in_depth < prev_depth_r) ||
                    ((in_depth == prev_depth_r) && (in_slot > prev_slot_r));
  assign better   = !found_r || (in_depth > best_depth_r);
  assign update   = ctl.take && eligible && better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      found_r <= 1'b0;
    end else begin
      if (ctl.draw_start) begin
        first_r <= 1'b1;
      end else if (ctl.commit) begin
        first_r <= 1'b0;
      end
      if (ctl.scan_start) begin
        found_r <= 1'b0;
      end else if (update) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      best_depth_r <= in_depth;
      best_tag_r   <= in_tag;
      best_slot_r  <= in_slot;
    end
    if (ctl.commit) begin
      prev_depth_r <= best_depth_r;
      prev_slot_r  <= best_slot_r;
    end
  end

  assign best_depth = best_depth_r;
  assign best_tag   = best_tag_r;
  assign best_slot  = best_slot_r;

endmodule

// ===== sv/depth_sort_face_order_unit.sv =====
// ----------------------------------------------------------------------------
// Depth sort face order unit
// Painter's-algorithm sorter: stores faces with depth keys and emits them
// from farthest to nearest on a draw, equal depths in insertion order.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_opcode, in_depth_key, in_face_tag
//   out_     output     out_valid/out_stall out_tag, out_depth, out_slot,
//                                           out_last, out_overflowed
//
// Add, clear and unused opcodes leave the block idle.
// A draw of n entries runs one full scan of the store RAM per emitted entry,
// while the input is stalled.
// The output register lets the block return to idle while the last result waits.
// Reset empties the store and clears the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module depth_sort_face_order_unit import dsfo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic signed [DEPTH_W-1:0] in_depth_key,
  input  logic [TAG_W-1:0]          in_face_tag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [TAG_W-1:0]          out_tag,
  output logic signed [DEPTH_W-1:0] out_depth,
  output logic [SLOT_W-1:0]         out_slot,
  output logic                      out_last,
  output logic                      out_overflowed
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic                      ovf_r;
  logic [CNT_W-1:0]          ra_r;
  logic [CNT_W-1:0]          emit_cnt_r;
  logic                      rd_vld_r;
  logic [SLOT_W-1:0]         rd_slot_r;
  logic                      out_valid_r;
  logic [TAG_W-1:0]          out_tag_r;
  logic signed [DEPTH_W-1:0] out_depth_r;
  logic [SLOT_W-1:0]         out_slot_r;
  logic                      out_last_r;
  logic                      out_ovf_r;

  opcode_t                   op;
  logic                      in_acc;
  logic                      wr_en;
  logic                      issue;
  logic                      scan_done;
  logic                      out_free;
  logic                      load;
  logic                      last_emit;
  logic [CNT_W-1:0]          emit_cnt_inc;
  logic [ENTRY_W-1:0]        rd_data;
  logic signed [DEPTH_W-1:0] best_depth;
  logic [TAG_W-1:0]          best_tag;
  logic [SLOT_W-1:0]         best_slot;
  sel_ctl_t                  sel_ctl;

  assign op        = opcode_t'(in_opcode);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign wr_en     = in_acc && (op == OP_ADD) && (cnt_r < CNT_W'(CAPACITY));
  assign issue     = (state_r == ST_SCAN) && (ra_r < cnt_r);
  assign scan_done = (state_r == ST_SCAN) && !issue && !rd_vld_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign load      = (state_r == ST_EMIT) && out_free;

  assign emit_cnt_inc = emit_cnt_r + CNT_W'(1);
  assign last_emit    = (emit_cnt_inc == cnt_r);

  assign sel_ctl.draw_start = in_acc && (op == OP_DRAW) && (cnt_r != '0);
  assign sel_ctl.scan_start = sel_ctl.draw_start || (load && !last_emit);
  assign sel_ctl.take       = rd_vld_r;
  assign sel_ctl.commit     = load;

  dsfo_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[SLOT_W-1:0]),
    .wdata ({in_depth_key, in_face_tag}),
    .re    (issue),
    .raddr (ra_r[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  dsfo_sel u_sel (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sel_ctl),
    .in_depth   (rd_data[ENTRY_W-1:TAG_W]),
    .in_tag     (rd_data[TAG_W-1:0]),
    .in_slot    (rd_slot_r),
    .best_depth (best_depth),
    .best_tag   (best_tag),
    .best_slot  (best_slot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sel_ctl.draw_start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          state_nxt = last_emit ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (in_acc && (op == OP_ADD)) begin
        if (wr_en) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end else if (in_acc && (op == OP_CLEAR)) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= ra_r[SLOT_W-1:0];
    if (sel_ctl.scan_start) begin
      ra_r <= '0;
    end else if (issue) begin
      ra_r <= ra_r + CNT_W'(1);
    end
    if (sel_ctl.draw_start) begin
      emit_cnt_r <= '0;
    end else if (load) begin
      emit_cnt_r <= emit_cnt_inc;
    end
    if (load) begin
      out_tag_r   <= best_tag;
      out_depth_r <= best_depth;
      out_slot_r  <= best_slot;
      out_last_r  <= last_emit;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tag        = out_tag_r;
  assign out_depth      = out_depth_r;
  assign out_slot       = out_slot_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

endmodule

// ===== verif/tb_depth_sort_face_order_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth sort face order unit testbench
// Sends add, draw, clear and unused-opcode transactions through the valid/stall
// input channel. A shadow copy of the face store predicts each draw run with
// no known result in the directed table, and each emitted face is compared
// against the expected faces in order. A directed table covers the extremes,
// ties, overflow and empty draws. Random scenes with gaps and stalls follow.
// ----------------------------------------------------------------------------
module tb_depth_sort_face_order_unit;
  import dsfo_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_CYCLES   = 5_000_000;
  localparam int DRAIN_CYCLES = CAPACITY * (CAPACITY + 2) + 64;
  localparam int ROWS         = 17;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [DEPTH_W-1:0] depth;
    logic [SLOT_W-1:0]         slot;
    logic                      last;
    logic                      ovf;
  } face_out_t;

  typedef struct packed {
    opcode_t            op;
    logic [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]   tag;
    logic [7:0]         reps;
    logic               known;
    logic [3:0]         known_first;
    logic [3:0]         known_n;
  } face_row_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic [1:0]                in_opcode    = OP_NONE;
  logic signed [DEPTH_W-1:0] in_depth_key = '0;
  logic [TAG_W-1:0]          in_face_tag  = '0;
  logic                      out_stall    = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic [TAG_W-1:0]          out_tag;
  logic signed [DEPTH_W-1:0] out_depth;
  logic [SLOT_W-1:0]         out_slot;
  logic                      out_last;
  logic                      out_overflowed;

  logic signed [DEPTH_W-1:0] shadow_depth [CAPACITY];
  logic [TAG_W-1:0]          shadow_tag [CAPACITY];
  int                        shadow_count = 0;
  logic                      shadow_ovf = 1'b0;
  face_out_t                 expected_faces [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_taken = 0;
  int draws_taken = 0;
  int overflow_draws = 0;
  int cycles = 0;

  // Fields: opcode, depth, tag, repeat count, known result, first, count.
  face_row_t directed_rows [ROWS] = '{
    '{OP_DRAW,  32'h0000_0000, 16'h0000, 8'd1,  1'b1, 4'd0, 4'd0},
    '{OP_ADD,   32'h7fff_ffff, 16'hffff, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_ADD,   32'h8000_0000, 16'h0000, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_ADD,   32'h0000_0000, 16'h1234, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_ADD,   32'h0000_0000, 16'h5678, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_DRAW,  32'h0000_0000, 16'h0000, 8'd1,  1'b1, 4'd0, 4'd4},
    '{OP_NONE,  32'hffff_ffff, 16'hffff, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_DRAW,  32'h0000_0000, 16'h0000, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_CLEAR, 32'h0000_0000, 16'h0000, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_DRAW,  32'h0000_0000, 16'h0000, 8'd1,  1'b1, 4'd0, 4'd0},
    '{OP_ADD,   32'h0001_0000, 16'h0100, 8'd65, 1'b0, 4'd0, 4'd0},
    '{OP_ADD,   32'h7fff_ffff, 16'habcd, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_DRAW,  32'h0000_0000, 16'h0000, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_CLEAR, 32'h0000_0000, 16'h0000, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_ADD,   32'hffff_ffff, 16'h8000, 8'd1,  1'b0, 4'd0, 4'd0},
    '{OP_DRAW,  32'h0000_0000, 16'h0000, 8'd1,  1'b1, 4'd4, 4'd1},
    '{OP_CLEAR, 32'h0000_0000, 16'h0000, 8'd1,  1'b0, 4'd0, 4'd0}
  };

  face_out_t known_faces [5] = '{
    '{16'hffff, 32'sh7fff_ffff, 6'd0, 1'b0, 1'b0},
    '{16'h1234, 32'sh0000_0000, 6'd2, 1'b0, 1'b0},
    '{16'h5678, 32'sh0000_0000, 6'd3, 1'b0, 1'b0},
    '{16'h0000, 32'sh8000_0000, 6'd1, 1'b1, 1'b0},
    '{16'h8000, 32'shffff_ffff, 6'd0, 1'b1, 1'b0}
  };

  depth_sort_face_order_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_depth_key  (in_depth_key),
    .in_face_tag   (in_face_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tag       (out_tag),
    .out_depth     (out_depth),
    .out_slot      (out_slot),
    .out_last      (out_last),
    .out_overflowed(out_overflowed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void push_depth_order();
    int order [CAPACITY];
    int i;
    int j;
    face_out_t f;
    for (i = 0; i < shadow_count; i++) begin
      j = i;
      while (j > 0 && shadow_depth[order[j-1]] < shadow_depth[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < shadow_count; i++) begin
      f.tag   = shadow_tag[order[i]];
      f.depth = shadow_depth[order[i]];
      f.slot  = SLOT_W'(order[i]);
      f.last  = (i == shadow_count - 1);
      f.ovf   = shadow_ovf;
      expected_faces.push_back(f);
    end
  endfunction

  function automatic void track_item(opcode_t op, logic [DEPTH_W-1:0] depth,
                                     logic [TAG_W-1:0] tag);
    case (op)
      OP_ADD: begin
        if (shadow_count < CAPACITY) begin
          shadow_depth[shadow_count] = depth;
          shadow_tag[shadow_count]   = tag;
          shadow_count++;
        end else begin
          shadow_ovf = 1'b1;
        end
      end
      OP_DRAW: begin
        if (shadow_ovf && shadow_count > 0) overflow_draws++;
        push_depth_order();
      end
      OP_CLEAR: begin
        shadow_count = 0;
        shadow_ovf   = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {16'($urandom_range(0, 4) - 2), 16'h0000};
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input opcode_t op, input logic [DEPTH_W-1:0] depth,
                           input logic [TAG_W-1:0] tag, input bit predict);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_depth_key <= depth;
    in_face_tag  <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_NONE) items_taken++;
    if (op == OP_DRAW) draws_taken++;
    if (predict) track_item(op, depth, tag);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == MAX_CYCLES) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    face_out_t got;
    face_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_tag, out_depth, out_slot, out_last, out_overflowed};
      results_seen++;
      if (expected_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected face: tag %h depth %h slot %0d last %b ovf %b",
                   got.tag, got.depth, got.slot, got.last, got.ovf);
      end else begin
        want = expected_faces.pop_front();
        if (got.tag != want.tag || got.depth != want.depth || got.slot != want.slot ||
            got.last != want.last || got.ovf != want.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Face %0d expected: tag %h depth %h slot %0d last %b ovf %b",
                     results_seen, want.tag, want.depth, want.slot, want.last, want.ovf);
            $display("Face %0d actual:   tag %h depth %h slot %0d last %b ovf %b",
                     results_seen, got.tag, got.depth, got.slot, got.last, got.ovf);
          end
        end
      end
    end
  end

  initial begin
    face_row_t row;
    int r;
    int k;
    int base;
    int scene;
    int nadd;
    bit big;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < ROWS; r++) begin
      row = directed_rows[r];
      for (k = 0; k < row.reps; k++)
        send_item(row.op, row.depth, row.tag + TAG_W'(k), !row.known);
      if (row.known)
        for (k = 0; k < row.known_n; k++)
          expected_faces.push_back(known_faces[row.known_first + k]);
    end

    base  = items_taken;
    scene = 0;
    while (items_taken - base < RANDOM_ITEMS) begin
      case (((items_taken - base) * 4) / RANDOM_ITEMS)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      big = (scene % 16 == 9);
      if (big || shadow_count > 20 || $urandom_range(0, 9) < 8)
        send_item(OP_CLEAR, $urandom, TAG_W'($urandom_range(0, 65535)), 1'b1);
      if ($urandom_range(0, 9) == 0)
        send_item(OP_DRAW, $urandom, TAG_W'($urandom_range(0, 65535)), 1'b1);
      nadd = big ? $urandom_range(58, 70) : $urandom_range(0, 10);
      for (k = 0; k < nadd; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_NONE, $urandom, TAG_W'($urandom_range(0, 65535)), 1'b1);
        send_item(OP_ADD, pick_depth(), TAG_W'($urandom_range(0, 65535)), 1'b1);
      end
      send_item(OP_DRAW, $urandom, TAG_W'($urandom_range(0, 65535)), 1'b1);
      if ($urandom_range(0, 3) == 0)
        send_item(OP_DRAW, $urandom, TAG_W'($urandom_range(0, 65535)), 1'b1);
      scene++;
    end
    in_valid <= 1'b0;

    while (expected_faces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Accepted %0d transactions in %0d scenes, with %0d draws, %0d with overflow.",
             items_taken, scene, draws_taken, overflow_draws);
    $display("Checked %0d emitted faces, %0d mismatches, in %0d cycles.",
             results_seen, mismatches, cycles);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
